/* rtl/piecewise_linear_resampler_top_macros.svh */
// assertion macros for the piecewise-linear resampler
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef PIECEWISE_LINEAR_RESAMPLER_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_RESAMPLER_TOP_MACROS_SVH

// condition must hold at every edge outside reset
`define PLR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PLR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/plr_pkg.sv */
// shared types and constants of the piecewise-linear resampler
// no dependencies
package plr_pkg;

    localparam int MAX_PER_KNOT = 64;
    localparam int COUNT_WIDTH  = 16;
    localparam int KCNT_W       = $clog2(MAX_PER_KNOT + 1);
    localparam int TIME_W       = 32;
    localparam int POS_W        = 32;
    localparam int GRID_W       = 48;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam int QUO_W        = 33;
    localparam int DVD_W        = 65;
    localparam int DSTEP_W      = $clog2(QUO_W + 1);

    localparam logic CFG_SAMPLE_STEP  = 1'b0;
    localparam logic CFG_SAMPLE_COUNT = 1'b1;

    typedef enum logic {
        K_LOAD,
        K_SEG
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [TIME_W-1:0]        knot_time;
        logic signed [POS_W-1:0]  knot_position;
    } t_cmd;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_PLAN,
        BS_CALC,
        BS_DSTART,
        BS_DIV,
        BS_EMIT,
        BS_SKST,
        BS_SKDIV,
        BS_SKMUL,
        BS_SKADD,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic              busy;
        logic [KCNT_W-1:0] kcnt;
    } t_back_stat;

endpackage

/* rtl/plr_div.sv */
// restoring divider, one quotient bit per cycle
// depends on plr_pkg
module plr_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [plr_pkg::DVD_W-1:0]          i_dividend,
    input  logic [plr_pkg::TIME_W-1:0]         i_divisor,
    output logic                               o_done,
    output logic [plr_pkg::QUO_W-1:0]          o_quo,
    output logic [plr_pkg::TIME_W-1:0]         o_rem
);
    logic [plr_pkg::TIME_W-1:0]  r_rem, n_rem;
    logic [plr_pkg::QUO_W-1:0]   r_low;
    logic [plr_pkg::QUO_W-1:0]   r_quo;
    logic [plr_pkg::TIME_W-1:0]  r_dsr;
    logic [plr_pkg::DSTEP_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [plr_pkg::TIME_W:0]    trial;
    logic                        qbit;

    always_comb begin
        trial = {r_rem, r_low[plr_pkg::QUO_W-1]};
        qbit  = (trial >= {1'b0, r_dsr});
        n_rem = qbit ? plr_pkg::TIME_W'(trial - {1'b0, r_dsr})
                     : trial[plr_pkg::TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= plr_pkg::DSTEP_W'(plr_pkg::QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == plr_pkg::DSTEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // top part of the dividend is known to be below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[plr_pkg::DVD_W-1:plr_pkg::QUO_W];
            r_low <= i_dividend[plr_pkg::QUO_W-1:0];
            r_dsr <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[plr_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[plr_pkg::QUO_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

/* rtl/plr_front.sv */
// front end: accepts knots, classifies them and queues them
// depends on plr_pkg
module plr_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_knot_valid,
    output logic                              o_knot_stall,
    input  logic [plr_pkg::TIME_W-1:0]        i_knot_time,
    input  logic signed [plr_pkg::POS_W-1:0]  i_knot_position,
    input  logic                              i_first_knot,
    output logic                              o_cmd_valid,
    output plr_pkg::t_cmd                     o_cmd,
    input  logic                              i_cmd_pop
);
    plr_pkg::t_cmd               r_mem [plr_pkg::QDEPTH];
    logic [plr_pkg::QPTR_W-1:0]  r_wp;
    logic [plr_pkg::QPTR_W-1:0]  r_rp;
    logic [plr_pkg::QCNT_W-1:0]  r_cnt;
    logic                        r_have_start;
    logic                        push;
    plr_pkg::t_cmd               cmd_in;

    assign o_knot_stall = (r_cnt == plr_pkg::QCNT_W'(plr_pkg::QDEPTH));
    assign push         = i_knot_valid && !o_knot_stall;
    assign o_cmd_valid  = (r_cnt != '0);
    assign o_cmd        = r_mem[r_rp];

    // any knot accepted leaves a start point behind
    always_comb begin
        cmd_in.kind          = (i_first_knot || !r_have_start) ? plr_pkg::K_LOAD
                                                               : plr_pkg::K_SEG;
        cmd_in.knot_time     = i_knot_time;
        cmd_in.knot_position = i_knot_position;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_rp         <= '0;
            r_cnt        <= '0;
            r_have_start <= 1'b0;
        end else begin
            if (push) begin
                r_wp         <= r_wp + 1'b1;
                r_have_start <= 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_cmd_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd_in;
        end
    end
endmodule

/* rtl/plr_back.sv */
// back end: trajectory state, per-sample interpolation, grid skip, output register
// depends on plr_pkg and plr_div
module plr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  plr_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_pop,
    input  logic [plr_pkg::TIME_W-1:0]        i_sample_step,
    input  logic [plr_pkg::COUNT_WIDTH-1:0]   i_sample_count,
    output logic                              o_sample_valid,
    input  logic                              i_sample_stall,
    output logic signed [plr_pkg::POS_W-1:0]  o_sample_value,
    output logic [15:0]                       o_sample_index,
    output logic                              o_last_in_run,
    output logic                              o_run_truncated,
    output plr_pkg::t_back_stat               o_stat
);
    localparam int TW = plr_pkg::TIME_W;
    localparam int CW = plr_pkg::COUNT_WIDTH;
    localparam int GW = plr_pkg::GRID_W;
    localparam int QW = plr_pkg::QUO_W;
    localparam int KW = plr_pkg::KCNT_W;

    plr_pkg::t_bstate            r_state, n_state;
    plr_pkg::t_cmd               r_cmd;
    logic [TW-1:0]               r_prev_time;
    logic signed [TW-1:0]        r_prev_pos;
    logic [GW-1:0]               r_ng;
    logic [CW-1:0]               r_sd;
    logic                        r_trunc;
    logic [KW-1:0]               r_k;
    logic [plr_pkg::DVD_W-1:0]   r_prod;
    logic signed [TW-1:0]        r_val;
    logic [QW-1:0]               r_q;
    logic                        r_out_valid;
    logic signed [TW-1:0]        r_out_value;
    logic [CW-1:0]               r_out_index;
    logic                        r_out_last;
    logic                        r_out_trunc;

    // datapath terms
    logic [TW-1:0]               t1;
    logic [TW:0]                 diff;
    logic                        neg;
    logic [QW-1:0]               mag;
    logic [TW-1:0]               den;
    logic                        direct;
    logic                        grid_below;
    logic                        count_left;
    logic [CW-1:0]               remaining;
    logic                        plan_trunc;
    logic [GW-1:0]               ng_next;
    logic                        is_last;
    logic                        out_free;
    logic [QW-1:0]               mul_a;
    logic [TW-1:0]               mul_b;
    logic [plr_pkg::DVD_W-1:0]   mul_p;
    logic                        div_start;
    logic [plr_pkg::DVD_W-1:0]   div_dvd;
    logic [TW-1:0]               div_dsr;
    logic                        div_done;
    logic [QW-1:0]               div_quo;
    logic [TW-1:0]               div_rem;
    logic                        rnd;
    logic [QW-1:0]               qr;
    logic [TW+1:0]               sval;
    logic [QW:0]                 sd_sum;
    logic [CW:0]                 sd_inc;
    logic                        emit_fire;
    logic                        cmd_pop;

    always_comb begin
        t1         = r_cmd.knot_time;
        diff       = {r_cmd.knot_position[TW-1], r_cmd.knot_position}
                   - {r_prev_pos[TW-1], r_prev_pos};
        neg        = diff[TW];
        mag        = neg ? QW'(-diff) : QW'(diff);
        den        = t1 - r_prev_time;
        direct     = (r_ng <= GW'(r_prev_time)) || (t1 <= r_prev_time);
        grid_below = (r_ng < GW'(t1));
        count_left = (r_sd < i_sample_count);
        remaining  = i_sample_count - r_sd;
        // more than MAX_PER_KNOT grid points iff distance exceeds MAX_PER_KNOT steps
        plan_trunc = grid_below && count_left
                   && (remaining > CW'(plr_pkg::MAX_PER_KNOT))
                   && ((GW'(t1) - r_ng) > (GW'(i_sample_step) * plr_pkg::MAX_PER_KNOT));
        ng_next    = r_ng + GW'(i_sample_step);
        sd_inc     = {1'b0, r_sd} + 1'b1;
        is_last    = (r_k == KW'(plr_pkg::MAX_PER_KNOT - 1))
                   || (sd_inc >= {1'b0, i_sample_count})
                   || (ng_next >= GW'(t1));
        out_free   = !r_out_valid || !i_sample_stall;
        rnd        = ({div_rem, 1'b0} >= {1'b0, den});
        qr         = div_quo + QW'(rnd);
        sval       = neg ? ({{2{r_prev_pos[TW-1]}}, r_prev_pos} - (TW+2)'(qr))
                         : ({{2{r_prev_pos[TW-1]}}, r_prev_pos} + (TW+2)'(qr));
        sd_sum     = (QW+1)'(r_sd) + (QW+1)'(r_q);
        mul_p      = plr_pkg::DVD_W'(mul_a) * plr_pkg::DVD_W'(mul_b);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            plr_pkg::BS_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = plr_pkg::BS_PLAN;
                end
            end
            plr_pkg::BS_PLAN: begin
                if (r_cmd.kind == plr_pkg::K_LOAD) begin
                    n_state = plr_pkg::BS_IDLE;
                end else if (grid_below && count_left) begin
                    n_state = plr_pkg::BS_CALC;
                end else begin
                    n_state = plr_pkg::BS_DONE;
                end
            end
            plr_pkg::BS_CALC:   n_state = direct ? plr_pkg::BS_EMIT : plr_pkg::BS_DSTART;
            plr_pkg::BS_DSTART: n_state = plr_pkg::BS_DIV;
            plr_pkg::BS_DIV: begin
                if (div_done) begin
                    n_state = plr_pkg::BS_EMIT;
                end
            end
            plr_pkg::BS_EMIT: begin
                if (out_free) begin
                    if (!is_last) begin
                        n_state = plr_pkg::BS_CALC;
                    end else if (r_trunc && (i_sample_step != '0)) begin
                        n_state = plr_pkg::BS_SKST;
                    end else begin
                        n_state = plr_pkg::BS_DONE;
                    end
                end
            end
            plr_pkg::BS_SKST:  n_state = plr_pkg::BS_SKDIV;
            plr_pkg::BS_SKDIV: begin
                if (div_done) begin
                    n_state = plr_pkg::BS_SKMUL;
                end
            end
            plr_pkg::BS_SKMUL: n_state = plr_pkg::BS_SKADD;
            plr_pkg::BS_SKADD: n_state = plr_pkg::BS_DONE;
            plr_pkg::BS_DONE:  n_state = plr_pkg::BS_IDLE;
            default:           n_state = plr_pkg::BS_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        cmd_pop   = 1'b0;
        div_start = 1'b0;
        emit_fire = 1'b0;
        mul_a     = mag;
        mul_b     = TW'(r_ng) - r_prev_time;
        div_dvd   = r_prod;
        div_dsr   = den;
        case (r_state)
            plr_pkg::BS_IDLE:   cmd_pop = i_cmd_valid;
            plr_pkg::BS_DSTART: div_start = 1'b1;
            plr_pkg::BS_EMIT:   emit_fire = out_free;
            plr_pkg::BS_SKST: begin
                // ceil of the distance left over the step
                div_start = 1'b1;
                div_dvd   = plr_pkg::DVD_W'(t1 - TW'(r_ng));
                div_dsr   = i_sample_step;
            end
            plr_pkg::BS_SKMUL: begin
                mul_a = r_q;
                mul_b = i_sample_step;
            end
            default: begin
            end
        endcase
    end

    plr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plr_pkg::BS_IDLE;
            r_out_valid <= 1'b0;
            r_prev_time <= '0;
            r_prev_pos  <= '0;
            r_ng        <= '0;
            r_sd        <= '0;
            r_trunc     <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= emit_fire || (r_out_valid && i_sample_stall);
            case (r_state)
                plr_pkg::BS_PLAN: begin
                    r_k <= '0;
                    if (r_cmd.kind == plr_pkg::K_LOAD) begin
                        r_prev_time <= r_cmd.knot_time;
                        r_prev_pos  <= r_cmd.knot_position;
                        r_ng        <= GW'(i_sample_step);
                        r_sd        <= '0;
                        r_trunc     <= 1'b0;
                    end else begin
                        r_trunc <= plan_trunc;
                    end
                end
                plr_pkg::BS_EMIT: begin
                    if (out_free) begin
                        r_ng <= ng_next;
                        r_sd <= sd_inc[CW-1:0];
                        r_k  <= r_k + 1'b1;
                    end
                end
                plr_pkg::BS_SKMUL: begin
                    r_sd <= (sd_sum > (QW+1)'(i_sample_count)) ? i_sample_count
                                                               : sd_sum[CW-1:0];
                end
                plr_pkg::BS_SKADD: r_ng <= r_ng + r_prod[GW-1:0];
                plr_pkg::BS_DONE: begin
                    r_prev_time <= r_cmd.knot_time;
                    r_prev_pos  <= r_cmd.knot_position;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if ((r_state == plr_pkg::BS_CALC) || (r_state == plr_pkg::BS_SKMUL)) begin
            r_prod <= mul_p;
        end
        if (r_state == plr_pkg::BS_CALC) begin
            r_val <= r_prev_pos;
        end else if ((r_state == plr_pkg::BS_DIV) && div_done) begin
            r_val <= sval[TW-1:0];
        end
        if ((r_state == plr_pkg::BS_SKDIV) && div_done) begin
            r_q <= div_quo + QW'(div_rem != '0);
        end
        if (emit_fire) begin
            r_out_value <= r_val;
            r_out_index <= r_sd;
            r_out_last  <= is_last;
            r_out_trunc <= r_trunc;
        end
    end

    assign o_cmd_pop       = cmd_pop;
    assign o_sample_valid  = r_out_valid;
    assign o_sample_value  = r_out_value;
    assign o_sample_index  = 16'(r_out_index);
    assign o_last_in_run   = r_out_last;
    assign o_run_truncated = r_out_trunc;
    assign o_stat.busy     = (r_state != plr_pkg::BS_IDLE);
    assign o_stat.kcnt     = r_k;
endmodule

/* rtl/piecewise_linear_resampler_top.sv */
// Piecewise-linear resampler, one coordinate.
// Knot channel: i_knot_valid / o_knot_stall carry knot_time (unsigned Q16.16),
// knot_position (signed Q16.16) and first_knot. A front end queues up to two knots.
// Sample channel: o_sample_valid / i_sample_stall carry the interpolated position,
// its grid index, last_in_run and run_truncated, from one output register.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 sample_step,
// index 1 sample_count; write only while the block is idle.
// A first knot only loads the start point. A segment knot is planned, then each
// sample takes a multiply, a serial divide and an emit; the divide is skipped
// when the grid point or the knot's time is at or before the previous knot's time.
// A truncated run adds a grid skip, again on the divider.
// The shared serial divider sets the rate: one quotient bit per cycle.
// Reset (synchronous, active low) empties the queue, drops any pending sample,
// sets sample_step to 1.0 and sample_count to 0 and forgets the start point.
// While i_sample_stall is high the back end holds its next sample and the
// queue fills; o_knot_stall rises once it holds two knots.
// depends on plr_pkg, plr_front, plr_back, plr_div and the macros header
`include "piecewise_linear_resampler_top_macros.svh"

module piecewise_linear_resampler_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_knot_valid,
    output logic                              o_knot_stall,
    input  logic [31:0]                       i_knot_time,
    input  logic signed [31:0]                i_knot_position,
    input  logic                              i_first_knot,
    output logic                              o_sample_valid,
    input  logic                              i_sample_stall,
    output logic signed [31:0]                o_sample_value,
    output logic [15:0]                       o_sample_index,
    output logic                              o_last_in_run,
    output logic                              o_run_truncated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    logic [plr_pkg::TIME_W-1:0]       r_sample_step;
    logic [plr_pkg::COUNT_WIDTH-1:0]  r_sample_count;
    logic                             cmd_valid;
    plr_pkg::t_cmd                    cmd;
    logic                             cmd_pop;
    plr_pkg::t_back_stat              stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_step  <= plr_pkg::TIME_W'(65536);
            r_sample_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                plr_pkg::CFG_SAMPLE_STEP:  r_sample_step  <= i_cfg_data;
                plr_pkg::CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[plr_pkg::COUNT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    plr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_knot_valid    (i_knot_valid),
        .o_knot_stall    (o_knot_stall),
        .i_knot_time     (i_knot_time),
        .i_knot_position (i_knot_position),
        .i_first_knot    (i_first_knot),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    plr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .i_sample_step   (r_sample_step),
        .i_sample_count  (r_sample_count),
        .o_sample_valid  (o_sample_valid),
        .i_sample_stall  (i_sample_stall),
        .o_sample_value  (o_sample_value),
        .o_sample_index  (o_sample_index),
        .o_last_in_run   (o_last_in_run),
        .o_run_truncated (o_run_truncated),
        .o_stat          (stat)
    );

    // a run never has more samples than the per-knot limit
    `PLR_ASSERT_ALWAYS(a_kcnt_bound, stat.kcnt <= plr_pkg::KCNT_W'(plr_pkg::MAX_PER_KNOT), "per-knot sample count over limit")
    // every pending sample lies below the configured total
    `PLR_ASSERT_IMP(a_index_bound, o_sample_valid, {16'h0, o_sample_index} < 32'(r_sample_count), "sample index beyond sample_count")
    // config writes must come only while the back end is idle; the block does not enforce this, the assertion flags it
    `PLR_ASSERT_IMP(a_cfg_idle, i_cfg_valid, !stat.busy, "config write while busy")
endmodule

/* tb/piecewise_linear_resampler_top_tb.sv */
// self-checking testbench for the piecewise-linear resampler top level
// depends on plr_pkg and piecewise_linear_resampler_top
`timescale 1ns / 100ps

module piecewise_linear_resampler_top_tb;

    typedef struct {
        logic [31:0]        knot_time;
        logic signed [31:0] knot_position;
        logic               first_knot;
    } t_knot;

    typedef struct {
        logic signed [31:0] value;
        logic [15:0]        index;
        logic               last;
        logic               trunc;
    } t_sample;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_knot_valid = 1'b0;
    logic               o_knot_stall;
    logic [31:0]        i_knot_time = '0;
    logic signed [31:0] i_knot_position = '0;
    logic               i_first_knot = 1'b0;
    logic               o_sample_valid;
    logic               i_sample_stall = 1'b0;
    logic signed [31:0] o_sample_value;
    logic [15:0]        o_sample_index;
    logic               o_last_in_run;
    logic               o_run_truncated;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = plr_pkg::CFG_SAMPLE_STEP;
    logic [31:0]        i_cfg_data = '0;

    piecewise_linear_resampler_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0]        step_reg = 32'd65536;
    logic [15:0]        count_reg = '0;
    logic [31:0]        prev_t = '0;
    logic signed [31:0] prev_x = '0;
    logic [47:0]        grid_t = '0;
    logic [16:0]        done_cnt = '0;
    logic               started = 1'b0;

    t_knot   knot_q[$];
    t_sample expect_q[$];
    int      errors = 0;
    int      samples_checked = 0;
    int      n_trunc = 0;
    int      n_knots = 0;
    int      idle_cycles = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] lerp(logic signed [31:0] x0,
            logic signed [31:0] x1, logic [47:0] t0, logic [47:0] t1, logic [47:0] t);
        logic signed [33:0] diff;
        logic [32:0]        mag;
        logic [47:0]        num, den;
        logic [95:0]        prod, q, r;
        if (t <= t0 || t1 <= t0) return x0;
        diff = x1 - x0;
        mag = diff < 0 ? 33'(-diff) : 33'(diff);
        num = t - t0;
        den = t1 - t0;
        if (num > den) num = den;
        prod = mag * num;
        q = prod / den;
        r = prod % den;
        if (2 * r >= den) q++;
        return diff < 0 ? 32'(x0 - $signed(q[33:0])) : 32'(x0 + $signed(q[33:0]));
    endfunction

    // work out the samples that one knot produces
    task automatic predict_knot(t_knot k);
        logic [63:0] pending, remaining, avail, emit, rest, s;
        logic        trunc;
        t_sample     smp;
        pending = 0;
        remaining = 0;
        if (k.first_knot || !started) begin
            prev_t = k.knot_time;
            prev_x = k.knot_position;
            grid_t = 48'(step_reg);
            done_cnt = 0;
            started = 1;
            return;
        end
        if (grid_t < k.knot_time && step_reg != 0)
            pending = (64'(k.knot_time) - grid_t + step_reg - 1) / step_reg;
        else if (grid_t < k.knot_time)
            pending = plr_pkg::MAX_PER_KNOT + 1;
        if (done_cnt < count_reg) remaining = count_reg - done_cnt;
        avail = pending < remaining ? pending : remaining;
        trunc = avail > plr_pkg::MAX_PER_KNOT;
        emit = trunc ? plr_pkg::MAX_PER_KNOT : avail;
        for (int i = 0; i < emit; i++) begin
            smp.value = lerp(prev_x, k.knot_position, prev_t, k.knot_time, grid_t);
            smp.index = done_cnt[15:0];
            smp.last = (i + 1 == emit);
            smp.trunc = trunc;
            expect_q.push_back(smp);
            if (done_cnt < 17'hFFFF) done_cnt++;
            grid_t = grid_t + step_reg;
        end
        if (trunc) n_trunc++;
        if (trunc && step_reg != 0) begin
            rest = pending - emit;
            grid_t = grid_t + 48'(rest * step_reg);
            s = done_cnt + rest;
            if (s > count_reg) s = count_reg;
            done_cnt = s[16:0];
        end
        prev_t = k.knot_time;
        prev_x = k.knot_position;
    endtask

    // knot driver
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_knot_valid && !o_knot_stall) begin
                predict_knot('{i_knot_time, i_knot_position, i_first_knot});
                n_knots++;
            end
            if (!i_knot_valid || !o_knot_stall) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    i_knot_valid <= 1'b0;
                end else if (knot_q.size() > 0) begin
                    t_knot k;
                    k = knot_q.pop_front();
                    i_knot_valid <= 1'b1;
                    i_knot_time <= k.knot_time;
                    i_knot_position <= k.knot_position;
                    i_first_knot <= k.first_knot;
                    drv_gap <= gap_len();
                end else begin
                    i_knot_valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_sample_valid && !i_sample_stall) begin
                t_sample e;
                samples_checked++;
                if (expect_q.size() == 0) begin
                    $error("unexpected sample transaction, index %0d", o_sample_index);
                    errors++;
                end else begin
                    e = expect_q.pop_front();
                    if (o_sample_value !== e.value) begin
                        $error("sample_value: expected %0d, got %0d", e.value, o_sample_value);
                        errors++;
                    end
                    if (o_sample_index !== e.index) begin
                        $error("sample_index: expected %0d, got %0d", e.index, o_sample_index);
                        errors++;
                    end
                    if (o_last_in_run !== e.last) begin
                        $error("last_in_run: expected %0d, got %0d", e.last, o_last_in_run);
                        errors++;
                    end
                    if (o_run_truncated !== e.trunc) begin
                        $error("run_truncated: expected %0d, got %0d", e.trunc,
                               o_run_truncated);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_sample_stall <= 1'b1;
            end else begin
                stall_left <= gap_len();
                i_sample_stall <= 1'b0;
            end
            if ((i_knot_valid && !o_knot_stall) || (o_sample_valid && !i_sample_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: no transaction for far longer than the slowest knot
    always @(posedge i_clk) begin
        if (idle_cycles > 20000) begin
            $display("piecewise_linear_resampler_top: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == plr_pkg::CFG_SAMPLE_STEP) step_reg = data;
        else count_reg = data[15:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (knot_q.size() > 0 || i_knot_valid || expect_q.size() > 0)
            @(posedge i_clk);
        // the last run's grid skip may still be on the divider
        repeat (200) @(posedge i_clk);
    endtask

    task automatic add_knot(logic [31:0] t, logic signed [31:0] x, logic f);
        t_knot k;
        k.knot_time = t;
        k.knot_position = x;
        k.first_knot = f;
        knot_q.push_back(k);
    endtask

    // random trajectory: start point, then mostly nondecreasing knots
    task automatic random_phase(int nknots, logic [31:0] max_adv);
        logic [31:0] t;
        t = $urandom_range(0, 32'h1000_0000);
        add_knot(t, $urandom, 1'b1);
        for (int i = 1; i < nknots; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 4) add_knot($urandom, $urandom, 1'b1);
            else if (r < 8) add_knot(t - $urandom_range(0, 65536), $urandom, 1'b0);
            else begin
                t = t + $urandom_range(0, max_adv);
                add_knot(t, r < 15 ? $urandom_range(0, 3) - 2 : $urandom, 1'b0);
            end
        end
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default count is zero: knots produce nothing
        add_knot(32'd0, 32'sd0, 1'b0);
        add_knot(32'h0004_0000, 32'sd5, 1'b0);
        drain();

        write_reg(plr_pkg::CFG_SAMPLE_COUNT, 32'd20);
        add_knot(32'd0, 32'sh7FFF_FFFF, 1'b1);
        add_knot(32'h0003_0000, 32'sh8000_0000, 1'b0);
        add_knot(32'h0003_0000, 32'sd7, 1'b0);
        add_knot(32'h0002_0000, -32'sd7, 1'b0);
        add_knot(32'h0005_8000, 32'sd3, 1'b0);
        add_knot(32'hFFFF_FFFF, 32'sd100, 1'b1);
        add_knot(32'hFFFF_FFFF, -32'sd100, 1'b0);
        drain();

        // truncated run and count cap
        write_reg(plr_pkg::CFG_SAMPLE_STEP, 32'd1);
        write_reg(plr_pkg::CFG_SAMPLE_COUNT, 32'd65535);
        add_knot(32'd0, 32'sd0, 1'b1);
        add_knot(32'd1000, 32'sh7FFF_FFFF, 1'b0);
        add_knot(32'd1010, -32'sd1, 1'b0);
        add_knot(32'hFFFF_FFFF, 32'sh8000_0000, 1'b0);
        drain();
        write_reg(plr_pkg::CFG_SAMPLE_STEP, 32'hFFFF_FFFF);
        add_knot(32'd0, 32'sd9, 1'b1);
        add_knot(32'hFFFF_FFFF, -32'sd9, 1'b0);
        drain();

        write_reg(plr_pkg::CFG_SAMPLE_STEP, 32'h0001_0000);
        write_reg(plr_pkg::CFG_SAMPLE_COUNT, 32'd300);
        random_phase(90, 32'h0008_0000);
        write_reg(plr_pkg::CFG_SAMPLE_STEP, 32'h0000_4000);
        write_reg(plr_pkg::CFG_SAMPLE_COUNT, 32'd65535);
        random_phase(90, 32'h0004_0000);
        write_reg(plr_pkg::CFG_SAMPLE_STEP, $urandom_range(1, 32'hFFFF_FFFF));
        write_reg(plr_pkg::CFG_SAMPLE_COUNT, 32'd40);
        random_phase(60, 32'hFFFF_FFFF);
        write_reg(plr_pkg::CFG_SAMPLE_STEP, 32'h0002_3000);
        write_reg(plr_pkg::CFG_SAMPLE_COUNT, $urandom_range(0, 65535));
        random_phase(110, 32'h0060_0000);

        $display("knots accepted %0d, samples checked %0d, truncated runs %0d",
                 n_knots, samples_checked, n_trunc);
        if (errors == 0 && expect_q.size() == 0)
            $display("piecewise_linear_resampler_top: match");
        else
            $display("piecewise_linear_resampler_top: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/plr_pkg.sv
rtl/plr_div.sv
rtl/plr_front.sv
rtl/plr_back.sv
rtl/piecewise_linear_resampler_top.sv
tb/piecewise_linear_resampler_top_tb.sv
